@@ rtl/smoothed_stepper_needle_driver_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the smoothed stepper needle driver
// Shared concurrent check forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SMOOTHED_STEPPER_NEEDLE_DRIVER_UNIT_MACROS_SVH
`define SMOOTHED_STEPPER_NEEDLE_DRIVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSND_ASSERT_HOLDS(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssnd: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SSND_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssnd: next-cycle check failed");

`endif

@@ rtl/ssnd_pkg.sv @@
// ----------------------------------------------------------------------------
// Smoothed stepper needle driver package
// Shared types, constants and helper functions.
// ----------------------------------------------------------------------------
package ssnd_pkg;

    // Width of the internal position arithmetic.
    localparam int POS_BITS = 10;
    localparam int WIDE_W   = POS_BITS + 6;
    localparam int POS_TOP  = (1 << POS_BITS) - 1;
    localparam logic signed [WIDE_W-1:0] POS_TOP_W = WIDE_W'(POS_TOP);

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Reset values of the registers and state.
    localparam logic [7:0]          ALPHA_RST    = 8'd38;
    localparam logic [7:0]          DEADBAND_RST = 8'd10;
    localparam logic [3:0]          BURST_RST    = 4'd3;
    localparam logic [9:0]          POS_MIN_RST  = 10'd80;
    localparam logic [9:0]          POS_MAX_RST  = 10'd420;
    localparam logic [9:0]          SOLID_RST    = 10'd500;
    localparam logic [9:0]          BLINK_RST    = 10'd100;
    localparam logic [POS_BITS-1:0] POS_RST      = POS_BITS'(250);

    localparam logic [3:0] BURST_MAX = 4'd8;

    // angle = floor(s * 6 / 5): divide by 5 through a reciprocal, exact below 16384.
    localparam logic [14:0] ANGLE_RECIP = 15'd13108;
    localparam int          ANGLE_SHIFT = 16;
    // floor(m / 120) through a reciprocal, exact for m below about 1.19 million.
    localparam logic [19:0] DIV120_RECIP = 20'd559241;
    localparam int          DIV120_SHIFT = 26;
    localparam logic signed [20:0] DIV120_BIAS = 21'sd119;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_MOTOR  = 2'd2,
        FUNC_LINK   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        REG_ALPHA       = 3'd0,
        REG_DEADBAND    = 3'd1,
        REG_BURST_STEPS = 3'd2,
        REG_POS_MIN     = 3'd3,
        REG_POS_MAX     = 3'd4,
        REG_SOLID_MS    = 3'd5,
        REG_BLINK_MS    = 3'd6
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL1,
        ST_MUL2,
        ST_ANGLE,
        ST_SPAN,
        ST_DIV,
        ST_TARGET,
        ST_EMIT,
        ST_STEP,
        ST_STEP_EMIT
    } state_t;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] deadband;
        logic [3:0] burst_steps;
        logic [9:0] pos_min;
        logic [9:0] pos_max;
        logic [9:0] solid_ms;
        logic [9:0] blink_ms;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic mul1;
        logic mul2;
        logic angle;
        logic span;
        logic div;
        logic target;
        logic step;
        logic emit;
        logic emit_step;
    } dp_cmd_t;

    typedef struct packed {
        logic move;
        logic last_step;
        logic out_free;
    } dp_stat_t;

    function automatic logic [3:0] coil_pattern(input logic [1:0] ph);
        logic [3:0] c;
        unique case (ph)
            2'd0: c = 4'b1010;
            2'd1: c = 4'b0110;
            2'd2: c = 4'b0101;
            2'd3: c = 4'b1001;
        endcase
        return c;
    endfunction

    function automatic logic [POS_BITS-1:0] sat_pos(input logic signed [WIDE_W-1:0] v);
        logic [POS_BITS-1:0] r;
        if (v < 0)
        begin
            r = '0;
        end
        else if (v > POS_TOP_W)
        begin
            r = '1;
        end
        else
        begin
            r = v[POS_BITS-1:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/ssnd_if.sv @@
// ----------------------------------------------------------------------------
// Smoothed stepper needle driver channels
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ssnd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] sample_value;
    logic       link_up;

    modport source (output valid, func, sample_value, link_up, input ready);
    modport sink   (input valid, func, sample_value, link_up, output ready);
endinterface

interface ssnd_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] coils;
    logic       step_taken;
    logic [9:0] position;
    logic [9:0] target;
    logic       led;
    logic       displaying;
    logic       last;

    modport source (output valid, coils, step_taken, position, target, led, displaying, last,
                    input ready);
    modport sink   (input valid, coils, step_taken, position, target, led, displaying, last,
                    output ready);
endinterface

@@ rtl/ssnd_regs.sv @@
// ----------------------------------------------------------------------------
// Smoothed stepper needle driver configuration registers
// APB-style register file holding the seven configuration registers.
// ----------------------------------------------------------------------------
module ssnd_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ssnd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ssnd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ssnd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready,
    output ssnd_pkg::cfg_t                   cfg
);
    import ssnd_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_ALPHA:       cfg_next.alpha       = pwdata[7:0];
                REG_DEADBAND:    cfg_next.deadband    = pwdata[7:0];
                REG_BURST_STEPS: cfg_next.burst_steps = pwdata[3:0];
                REG_POS_MIN:     cfg_next.pos_min     = pwdata[9:0];
                REG_POS_MAX:     cfg_next.pos_max     = pwdata[9:0];
                REG_SOLID_MS:    cfg_next.solid_ms    = pwdata[9:0];
                REG_BLINK_MS:    cfg_next.blink_ms    = pwdata[9:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_ALPHA:       prdata = CFG_DATA_W'(cfg_reg.alpha);
            REG_DEADBAND:    prdata = CFG_DATA_W'(cfg_reg.deadband);
            REG_BURST_STEPS: prdata = CFG_DATA_W'(cfg_reg.burst_steps);
            REG_POS_MIN:     prdata = CFG_DATA_W'(cfg_reg.pos_min);
            REG_POS_MAX:     prdata = CFG_DATA_W'(cfg_reg.pos_max);
            REG_SOLID_MS:    prdata = CFG_DATA_W'(cfg_reg.solid_ms);
            REG_BLINK_MS:    prdata = CFG_DATA_W'(cfg_reg.blink_ms);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha       <= ALPHA_RST;
            cfg_reg.deadband    <= DEADBAND_RST;
            cfg_reg.burst_steps <= BURST_RST;
            cfg_reg.pos_min     <= POS_MIN_RST;
            cfg_reg.pos_max     <= POS_MAX_RST;
            cfg_reg.solid_ms    <= SOLID_RST;
            cfg_reg.blink_ms    <= BLINK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/ssnd_ctrl.sv @@
// ----------------------------------------------------------------------------
// Smoothed stepper needle driver controller
// Sequences the datapath through each item and paces result delivery.
// ----------------------------------------------------------------------------
module ssnd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [1:0]         in_func,
    output logic               in_ready,
    output ssnd_pkg::dp_cmd_t  cmd,
    input  ssnd_pkg::dp_stat_t stat
);
    import ssnd_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign accept = in_valid && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (func_t'(in_func))
                        FUNC_SAMPLE: state_next = ST_MUL1;
                        FUNC_TICK:   state_next = ST_EMIT;
                        FUNC_MOTOR:  state_next = ST_DECIDE;
                        FUNC_LINK:   state_next = ST_EMIT;
                    endcase
                end
            end
            ST_DECIDE:    state_next = stat.move ? ST_STEP : ST_EMIT;
            ST_MUL1:      state_next = ST_MUL2;
            ST_MUL2:      state_next = ST_ANGLE;
            ST_ANGLE:     state_next = ST_SPAN;
            ST_SPAN:      state_next = ST_DIV;
            ST_DIV:       state_next = ST_TARGET;
            ST_TARGET:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_STEP:      state_next = ST_STEP_EMIT;
            ST_STEP_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.last_step ? ST_IDLE : ST_STEP;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        cmd.accept    = accept;
        cmd.mul1      = (state_reg == ST_MUL1);
        cmd.mul2      = (state_reg == ST_MUL2);
        cmd.angle     = (state_reg == ST_ANGLE);
        cmd.span      = (state_reg == ST_SPAN);
        cmd.div       = (state_reg == ST_DIV);
        cmd.target    = (state_reg == ST_TARGET);
        cmd.step      = (state_reg == ST_STEP);
        cmd.emit      = (state_reg == ST_EMIT) && stat.out_free;
        cmd.emit_step = (state_reg == ST_STEP_EMIT) && stat.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/ssnd_dp.sv @@
// ----------------------------------------------------------------------------
// Smoothed stepper needle driver datapath
// Average, target map, LED timers, stepping and the output register.
// ----------------------------------------------------------------------------
`include "smoothed_stepper_needle_driver_unit_macros.svh"

module ssnd_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  ssnd_pkg::cfg_t     cfg,
    input  ssnd_pkg::dp_cmd_t  cmd,
    output ssnd_pkg::dp_stat_t stat,
    input  logic [1:0]         in_func,
    input  logic [7:0]         in_sample_value,
    input  logic               in_link_up,
    ssnd_out_if.source         out_ch
);
    import ssnd_pkg::*;

    // Architectural state.
    logic [15:0]         smoothed_reg, smoothed_next;
    logic [POS_BITS-1:0] target_reg, target_next;
    logic [POS_BITS-1:0] motor_pos_reg, motor_pos_next;
    logic [1:0]          phase_reg, phase_next;
    logic                link_active_reg, link_active_next;
    logic [9:0]          since_sample_reg, since_sample_next;
    logic [9:0]          since_toggle_reg, since_toggle_next;
    logic                blink_level_reg, blink_level_next;

    // Sequencing state.
    logic [3:0]          steps_left_reg, steps_left_next;
    logic                last_flag_reg, last_flag_next;
    logic                move_reg, move_next;
    logic                out_valid_reg, out_valid_next;

    // Scratch registers.
    logic [7:0]               sample_reg, sample_next;
    logic [24:0]              prod1_reg, prod1_next;
    logic [8:0]               angle_reg, angle_next;
    logic signed [10:0]       span_reg, span_next;
    logic signed [20:0]       num_reg, num_next;
    logic [11:0]              q_reg, q_next;
    logic                     neg_reg, neg_next;
    logic signed [WIDE_W-1:0] pos_work_reg, pos_work_next;
    logic                     dir_up_reg, dir_up_next;

    // Output payload.
    logic [3:0] o_coils_reg, o_coils_next;
    logic       o_step_reg, o_step_next;
    logic [9:0] o_pos_reg, o_pos_next;
    logic [9:0] o_tgt_reg, o_tgt_next;
    logic       o_led_reg, o_led_next;
    logic       o_disp_reg, o_disp_next;
    logic       o_last_reg, o_last_next;

    // Combinational terms.
    logic [8:0]               keep_w;
    logic [24:0]              mul1_prod;
    logic [23:0]              mul2_prod;
    logic [24:0]              acc;
    logic [10:0]              angle_x;
    logic [25:0]              angle_prod;
    logic signed [20:0]       num_prod;
    logic signed [20:0]       mag_w;
    logic [39:0]              div_prod;
    logic signed [WIDE_W-1:0] q_signed;
    logic signed [WIDE_W-1:0] t_w;
    logic signed [WIDE_W-1:0] diff;
    logic signed [WIDE_W-1:0] mag_d;
    logic                     move_w;
    logic [3:0]               burst_n;
    logic signed [WIDE_W-1:0] step_pos;
    logic signed [WIDE_W-1:0] pmin_w;
    logic signed [WIDE_W-1:0] pmax_w;
    logic signed [WIDE_W-1:0] clamp_pos;
    logic [POS_BITS-1:0]      clamp_sat;
    logic [9:0]               ss_inc;
    logic [9:0]               st_inc;
    logic                     out_free;
    logic                     load_out;

    // Exponential average: the kept share in one cycle, the new share and the sum in the next.
    assign keep_w    = 9'd256 - {1'b0, cfg.alpha};
    assign mul1_prod = 25'(smoothed_reg) * 25'(keep_w);
    assign mul2_prod = 24'({sample_reg, 8'h00}) * 24'(cfg.alpha);
    assign acc       = prod1_reg + {1'b0, mul2_prod};

    // Angle is floor(s * 6 / 5) with s the integer part of the average.
    assign angle_x    = {1'b0, smoothed_reg[15:8], 2'b00} + {2'b00, smoothed_reg[15:8], 1'b0};
    assign angle_prod = 26'(angle_x) * 26'(ANGLE_RECIP);

    // Target map numerator and floored division by 120.
    assign num_prod = 21'($signed({1'b0, angle_reg})) * 21'(span_reg);
    assign mag_w    = num_reg[20] ? (DIV120_BIAS - num_reg) : num_reg;
    assign div_prod = 40'(mag_w[19:0]) * 40'(DIV120_RECIP);
    assign q_signed = neg_reg ? -$signed(WIDE_W'(q_reg)) : $signed(WIDE_W'(q_reg));
    assign t_w      = $signed(WIDE_W'(cfg.pos_min)) + q_signed;

    // Motor decision.
    assign diff    = $signed(WIDE_W'(target_reg)) - $signed(WIDE_W'(motor_pos_reg));
    assign mag_d   = (diff < 0) ? -diff : diff;
    assign move_w  = link_active_reg && (mag_d > $signed(WIDE_W'(cfg.deadband)));
    assign burst_n = (cfg.burst_steps == 4'd0) ? 4'd1 :
                     ((cfg.burst_steps > BURST_MAX) ? BURST_MAX : cfg.burst_steps);

    // One step, with the end-of-burst clamp.
    assign step_pos  = dir_up_reg ? (pos_work_reg + $signed(WIDE_W'(1)))
                                  : (pos_work_reg - $signed(WIDE_W'(1)));
    assign pmin_w    = $signed(WIDE_W'(cfg.pos_min));
    assign pmax_w    = $signed(WIDE_W'(cfg.pos_max));
    assign clamp_pos = (step_pos < pmin_w) ? pmin_w :
                       ((step_pos > pmax_w) ? pmax_w : step_pos);
    assign clamp_sat = sat_pos(clamp_pos);

    // Millisecond counters saturate at all ones.
    assign ss_inc = (since_sample_reg == '1) ? since_sample_reg : since_sample_reg + 10'd1;
    assign st_inc = (since_toggle_reg == '1) ? since_toggle_reg : since_toggle_reg + 10'd1;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign load_out = cmd.emit || cmd.emit_step;

    always_comb
    begin
        smoothed_next     = smoothed_reg;
        target_next       = target_reg;
        motor_pos_next    = motor_pos_reg;
        phase_next        = phase_reg;
        link_active_next  = link_active_reg;
        since_sample_next = since_sample_reg;
        since_toggle_next = since_toggle_reg;
        blink_level_next  = blink_level_reg;
        steps_left_next   = steps_left_reg;
        last_flag_next    = last_flag_reg;
        move_next         = move_reg;
        sample_next       = sample_reg;
        prod1_next        = prod1_reg;
        angle_next        = angle_reg;
        span_next         = span_reg;
        num_next          = num_reg;
        q_next            = q_reg;
        neg_next          = neg_reg;
        pos_work_next     = pos_work_reg;
        dir_up_next       = dir_up_reg;

        if (cmd.accept)
        begin
            unique case (func_t'(in_func))
                FUNC_SAMPLE: sample_next = in_sample_value;
                FUNC_TICK:
                begin
                    since_sample_next = ss_inc;
                    if ((ss_inc >= cfg.solid_ms) && (st_inc > cfg.blink_ms))
                    begin
                        since_toggle_next = '0;
                        blink_level_next  = ~blink_level_reg;
                    end
                    else
                    begin
                        since_toggle_next = st_inc;
                    end
                end
                FUNC_MOTOR:
                begin
                    move_next       = move_w;
                    dir_up_next     = (diff > 0);
                    steps_left_next = burst_n;
                    pos_work_next   = WIDE_W'(motor_pos_reg);
                end
                FUNC_LINK:   link_active_next = in_link_up;
            endcase
        end

        if (cmd.mul1)
        begin
            prod1_next = mul1_prod;
        end
        if (cmd.mul2)
        begin
            smoothed_next = acc[23:8];
        end
        if (cmd.angle)
        begin
            angle_next = angle_prod[ANGLE_SHIFT +: 9];
            span_next  = $signed({1'b0, cfg.pos_max}) - $signed({1'b0, cfg.pos_min});
        end
        if (cmd.span)
        begin
            num_next = num_prod;
        end
        if (cmd.div)
        begin
            q_next   = div_prod[DIV120_SHIFT +: 12];
            neg_next = num_reg[20];
        end
        if (cmd.target)
        begin
            target_next       = sat_pos(t_w);
            since_sample_next = '0;
        end
        if (cmd.step)
        begin
            phase_next      = dir_up_reg ? phase_reg + 2'd1 : phase_reg - 2'd1;
            steps_left_next = steps_left_reg - 4'd1;
            last_flag_next  = (steps_left_reg == 4'd1);
            if (steps_left_reg == 4'd1)
            begin
                pos_work_next  = WIDE_W'(clamp_sat);
                motor_pos_next = clamp_sat;
            end
            else
            begin
                pos_work_next = step_pos;
            end
        end
    end

    // Output register: loaded only when empty or being drained.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        o_coils_next   = o_coils_reg;
        o_step_next    = o_step_reg;
        o_pos_next     = o_pos_reg;
        o_tgt_next     = o_tgt_reg;
        o_led_next     = o_led_reg;
        o_disp_next    = o_disp_reg;
        o_last_next    = o_last_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            o_coils_next   = coil_pattern(phase_reg);
            o_step_next    = cmd.emit_step;
            o_pos_next     = cmd.emit_step ? 10'(sat_pos(pos_work_reg)) : 10'(motor_pos_reg);
            o_tgt_next     = 10'(target_reg);
            o_led_next     = (since_sample_reg < cfg.solid_ms) || blink_level_reg;
            o_disp_next    = link_active_reg;
            o_last_next    = cmd.emit_step ? last_flag_reg : 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothed_reg     <= '0;
            target_reg       <= POS_RST;
            motor_pos_reg    <= POS_RST;
            phase_reg        <= '0;
            link_active_reg  <= 1'b0;
            since_sample_reg <= '0;
            since_toggle_reg <= '0;
            blink_level_reg  <= 1'b0;
            steps_left_reg   <= '0;
            last_flag_reg    <= 1'b0;
            move_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            smoothed_reg     <= smoothed_next;
            target_reg       <= target_next;
            motor_pos_reg    <= motor_pos_next;
            phase_reg        <= phase_next;
            link_active_reg  <= link_active_next;
            since_sample_reg <= since_sample_next;
            since_toggle_reg <= since_toggle_next;
            blink_level_reg  <= blink_level_next;
            steps_left_reg   <= steps_left_next;
            last_flag_reg    <= last_flag_next;
            move_reg         <= move_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg   <= sample_next;
        prod1_reg    <= prod1_next;
        angle_reg    <= angle_next;
        span_reg     <= span_next;
        num_reg      <= num_next;
        q_reg        <= q_next;
        neg_reg      <= neg_next;
        pos_work_reg <= pos_work_next;
        dir_up_reg   <= dir_up_next;
        o_coils_reg  <= o_coils_next;
        o_step_reg   <= o_step_next;
        o_pos_reg    <= o_pos_next;
        o_tgt_reg    <= o_tgt_next;
        o_led_reg    <= o_led_next;
        o_disp_reg   <= o_disp_next;
        o_last_reg   <= o_last_next;
    end

    assign stat.move      = move_reg;
    assign stat.last_step = last_flag_reg;
    assign stat.out_free  = out_free;

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.coils      = o_coils_reg;
    assign out_ch.step_taken = o_step_reg;
    assign out_ch.position   = o_pos_reg;
    assign out_ch.target     = o_tgt_reg;
    assign out_ch.led        = o_led_reg;
    assign out_ch.displaying = o_disp_reg;
    assign out_ch.last       = o_last_reg;

    // The controller must never overwrite a result that has not been taken.
    `SSND_ASSERT_HOLDS(a_load_only_when_free, load_out, out_free)
    // A step is only ever taken with steps left in the burst.
    `SSND_ASSERT_HOLDS(a_step_has_budget, cmd.step, steps_left_reg != 4'd0)
    // With sane bounds, the final step of a burst lands inside them.
    `SSND_ASSERT_HOLDS(a_burst_end_in_bounds,
        out_ch.valid && out_ch.last && out_ch.step_taken && (cfg.pos_min <= cfg.pos_max)
            && (32'(cfg.pos_max) <= 32'(POS_TOP)),
        (out_ch.position >= cfg.pos_min) && (out_ch.position <= cfg.pos_max))
    // The LED blink level changes only as a result of a millisecond tick.
    `SSND_ASSERT_HOLDS(a_blink_only_on_tick, blink_level_reg != $past(blink_level_reg),
        $past(cmd.accept) && ($past(in_func) == FUNC_TICK))
    // No motion is decided while the link is down.
    `SSND_ASSERT_NEXT(a_no_move_unlinked,
        cmd.accept && (in_func == FUNC_MOTOR) && !link_active_reg, !move_reg)

endmodule

@@ rtl/smoothed_stepper_needle_driver_unit.sv @@
// ----------------------------------------------------------------------------
// Smoothed stepper needle driver unit
// Event-driven needle controller: averaged samples, LED timing and stepping.
// ----------------------------------------------------------------------------
// Each input item is one event: a sample byte (func 0), a millisecond tick
// (func 1), a motor update (func 2) or a link event (func 3). A sample updates
// an unsigned Q8.8 moving average weighted by alpha/256, maps its integer part
// to an angle of floor(s*6/5) and from there to a target position of
// pos_min + floor(angle*(pos_max-pos_min)/120), saturated to 0..1023. Ticks
// advance the LED timers; the LED is solid for solid_ms after a sample and
// otherwise toggles whenever more than blink_ms have passed. A motor update,
// honored only while the link is up, moves the needle burst_steps (limited to
// 1..8) full steps toward the target once the error exceeds the deadband,
// giving one result per step with the two-phase coil pattern; the final
// position of a burst is clamped to pos_min..pos_max. Every other item gives
// one result, and the final result of an item carries last. Sequencing: one
// item is worked on at a time. A tick or a link event goes from acceptance
// straight to loading its result in the output register, and a motor update
// first passes the move decision; a sample runs the average through two
// registered multiplier stages, the angle, the span product and the division
// by 120 through one each, and the target is then saturated; a burst computes
// each step and then loads its result, step after step until the last. The
// output register lets the next item be accepted while the last result is
// still waiting to be taken; a stalled output holds the sequencer at its
// next result. Configuration goes through the APB-style port at byte address
// 4*i for register i (alpha, deadband, burst_steps, pos_min, pos_max,
// solid_ms, blink_ms) and must only be written while the unit is idle.
module smoothed_stepper_needle_driver_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    ssnd_in_if.sink                          in_ch,
    ssnd_out_if.source                       out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ssnd_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [ssnd_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [ssnd_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import ssnd_pkg::*;

    cfg_t     cfg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Configuration registers, read by the datapath as a single struct.
    ssnd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // The controller owns input acceptance and steps the datapath through
    // the multiply chain of a sample or the steps of a burst.
    ssnd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_func  (in_ch.func),
        .in_ready (in_ch.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds all needle, filter and LED state plus the output
    // register that drives the result channel.
    ssnd_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .stat            (stat),
        .in_func         (in_ch.func),
        .in_sample_value (in_ch.sample_value),
        .in_link_up      (in_ch.link_up),
        .out_ch          (out_ch)
    );

endmodule
